>>> rtl/hsvc_pkg.sv
package hsvc_pkg;

    // Top output brightness; the channel divisor follows from it
    localparam int unsigned MAX_LEVEL   = 255;
    localparam int unsigned DEPTH_RAW   = (255 * 255) / MAX_LEVEL;
    localparam int unsigned CH_DIVISOR  = ((DEPTH_RAW % 65536) == 0) ? 1 : (DEPTH_RAW % 65536);
    // ceil(2^32 / divisor): exact floor quotient for any 16-bit dividend
    localparam logic [63:0] CH_RECIP_W  = ((64'd1 << 32) + 64'(CH_DIVISOR) - 64'd1)
                                          / 64'(CH_DIVISOR);
    localparam logic [24:0] CH_RECIP    = CH_RECIP_W[24:0];

    // Reciprocals for the constant divisions, each exact over its input range
    localparam logic [15:0] RECIP_360   = 16'd46604;   // 2^24 / 360, rounded up
    localparam logic [16:0] RECIP_120   = 17'd69906;   // 2^23 / 120, rounded up
    localparam logic [10:0] RECIP_60    = 11'd1093;    // 2^16 / 60, rounded up

    localparam logic [8:0]  CIRCLE_DEG  = 9'd360;
    localparam logic [5:0]  SECTOR_DEG  = 6'd60;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;

    // Mid queue between front and back
    localparam int unsigned MQ_DEPTH    = 4;
    localparam int unsigned MQ_AW       = 2;

    typedef enum logic [2:0] {
        SECT_0 = 3'd0,
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
    } t_hsv_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_out;

    // Classified word handed from front to back
    typedef struct packed {
        t_sector     sect;
        logic [5:0]  offs;
        logic [9:0]  incline;
        logic [15:0] floor_t;
        logic [15:0] ceil_t;
        logic [15:0] half;
    } t_mid;

endpackage

>>> rtl/hsvc_front.sv
module hsvc_front import hsvc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_hsv_in i_hsv,
    output logic    o_full,
    output logic    o_q_push,
    output t_mid    o_q_data,
    input  logic    i_q_full
);

    logic        en;
    logic        r_v1, r_v2, r_v3, r_v4;

    logic [15:0] r_s1_hue;
    logic [7:0]  r_s1_q;
    logic [15:0] r_s1_vs, r_s1_ceil, r_s1_floor;

    logic [8:0]  r_s2_h;
    logic [9:0]  r_s2_incline;
    logic [15:0] r_s2_ceil, r_s2_floor, r_s2_half;

    logic [8:0]  r_s3_h;
    logic [2:0]  r_s3_sect;
    logic [9:0]  r_s3_incline;
    logic [15:0] r_s3_ceil, r_s3_floor, r_s3_half;

    t_mid        r_s4_mid;

    logic [31:0] p_q;
    logic [15:0] p_vs, p_ceil, p_floor;
    logic [15:0] q_mul, h_raw, h_fix;
    logic [32:0] p_inc;
    logic [19:0] p_sect;
    logic [8:0]  sect_mul, offs_w;

    // Whole front advances unless the last stage is blocked by the queue
    assign en       = !(r_v4 && i_q_full);
    assign o_full   = !en;
    assign o_q_push = r_v4 && !i_q_full;
    assign o_q_data = r_s4_mid;

    // Stage 1 products: hue quotient by 360 and the brightness terms
    always_comb begin
        p_q     = 32'(i_hsv.hue) * 32'(RECIP_360);
        p_vs    = 16'(i_hsv.val) * 16'(i_hsv.sat);
        p_ceil  = 16'(i_hsv.val) * 16'(FULL_SCALE);
        p_floor = 16'(i_hsv.val) * 16'(FULL_SCALE - i_hsv.sat);
    end

    // Stage 2: hue remainder and incline = vs / 120
    always_comb begin
        q_mul = 16'(r_s1_q) * 16'(CIRCLE_DEG);
        h_raw = r_s1_hue - q_mul;
        h_fix = (h_raw >= 16'(CIRCLE_DEG)) ? (h_raw - 16'(CIRCLE_DEG)) : h_raw;
        p_inc = 33'(r_s1_vs) * 33'(RECIP_120);
    end

    // Stage 3: sector = h / 60; stage 4: offset within the sector
    always_comb begin
        p_sect   = 20'(r_s2_h) * 20'(RECIP_60);
        sect_mul = 9'(r_s3_sect) * 9'(SECTOR_DEG);
        offs_w   = r_s3_h - sect_mul;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_hue     <= i_hsv.hue;
            r_s1_q       <= p_q[31:24];
            r_s1_vs      <= p_vs;
            r_s1_ceil    <= p_ceil;
            r_s1_floor   <= p_floor;

            r_s2_h       <= h_fix[8:0];
            r_s2_incline <= p_inc[32:23];
            r_s2_ceil    <= r_s1_ceil;
            r_s2_floor   <= r_s1_floor;
            r_s2_half    <= {1'b0, r_s1_vs[15:1]};

            r_s3_h       <= r_s2_h;
            r_s3_sect    <= p_sect[18:16];
            r_s3_incline <= r_s2_incline;
            r_s3_ceil    <= r_s2_ceil;
            r_s3_floor   <= r_s2_floor;
            r_s3_half    <= r_s2_half;

            r_s4_mid.sect    <= t_sector'(r_s3_sect);
            r_s4_mid.offs    <= offs_w[5:0];
            r_s4_mid.incline <= r_s3_incline;
            r_s4_mid.floor_t <= r_s3_floor;
            r_s4_mid.ceil_t  <= r_s3_ceil;
            r_s4_mid.half    <= r_s3_half;
        end
    end

endmodule

>>> rtl/hsvc_queue.sv
module hsvc_queue import hsvc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_mid i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_mid o_data
);

    t_mid             r_mem [MQ_DEPTH];
    logic [MQ_AW-1:0] r_wr, r_rd;
    logic [MQ_AW:0]   r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (MQ_AW+1)'(MQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (!do_push && do_pop) r_count <= r_count - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (MQ_AW+1)'(MQ_DEPTH))
        else $error("mid queue overfilled");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("front pushed into a full mid queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("mid queue count did not follow a push");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> (r_wr == r_rd))
        else $error("empty mid queue with unequal pointers");

endmodule

>>> rtl/hsvc_back.sv
module hsvc_back import hsvc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_empty,
    input  t_mid     i_q_data,
    output logic     o_q_pop,
    output logic     o_empty,
    input  logic     i_pop,
    output t_rgb_out o_rgb
);

    logic        en;
    logic        r_v1, r_v2, r_v3;

    t_sector     r_s1_sect;
    logic [15:0] r_s1_step, r_s1_floor, r_s1_ceil, r_s1_half;
    logic [15:0] r_s2_r, r_s2_g, r_s2_b;
    t_rgb_out    r_s3_rgb;

    logic [15:0] p_step;
    logic [15:0] ra, rb, rc, rd;
    logic [15:0] n_r, n_g, n_b;
    logic [40:0] p_r, p_g, p_b;

    // Output skid: two words
    t_rgb_out    r_out [2];
    logic        r_owr, r_ord;
    logic [1:0]  r_ocnt;
    logic        out_full, out_push, out_pop;

    assign out_full = (r_ocnt == 2'd2);
    assign en       = !(r_v3 && out_full);
    assign o_q_pop  = en && !i_q_empty;
    assign out_push = r_v3 && !out_full;
    assign out_pop  = i_pop && (r_ocnt != 2'd0);
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_rgb    = r_out[r_ord];

    // Stage 1: step = incline * offset, wraps at 16 bits
    assign p_step = 16'(i_q_data.incline) * 16'(i_q_data.offs);

    // Stage 2: ramps and sector routing
    always_comb begin
        ra = r_s1_floor + r_s1_step;
        rb = r_s1_floor + r_s1_half + r_s1_step;
        rc = r_s1_ceil - r_s1_step;
        rd = r_s1_ceil - r_s1_half - r_s1_step;
        unique case (r_s1_sect)
            SECT_0:  begin n_r = rc;         n_g = ra;         n_b = r_s1_floor; end
            SECT_1:  begin n_r = rd;         n_g = rb;         n_b = r_s1_floor; end
            SECT_2:  begin n_r = r_s1_floor; n_g = rc;         n_b = ra;         end
            SECT_3:  begin n_r = r_s1_floor; n_g = rd;         n_b = rb;         end
            SECT_4:  begin n_r = ra;         n_g = r_s1_floor; n_b = rc;         end
            SECT_5:  begin n_r = rb;         n_g = r_s1_floor; n_b = rd;         end
            default: begin n_r = rb;         n_g = r_s1_floor; n_b = rd;         end
        endcase
    end

    // Stage 3: channel / divisor through the reciprocal, low 8 bits kept
    always_comb begin
        p_r = 41'(r_s2_r) * 41'(CH_RECIP);
        p_g = 41'(r_s2_g) * 41'(CH_RECIP);
        p_b = 41'(r_s2_b) * 41'(CH_RECIP);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= o_q_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sect  <= i_q_data.sect;
            r_s1_step  <= p_step;
            r_s1_floor <= i_q_data.floor_t;
            r_s1_ceil  <= i_q_data.ceil_t;
            r_s1_half  <= i_q_data.half;

            r_s2_r <= n_r;
            r_s2_g <= n_g;
            r_s2_b <= n_b;

            r_s3_rgb.red   <= p_r[39:32];
            r_s3_rgb.green <= p_g[39:32];
            r_s3_rgb.blue  <= p_b[39:32];
        end
    end

    // Output skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (out_push) r_owr <= !r_owr;
            if (out_pop)  r_ord <= !r_ord;
            if (out_push && !out_pop)      r_ocnt <= r_ocnt + 2'd1;
            else if (!out_push && out_pop) r_ocnt <= r_ocnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) r_out[r_owr] <= r_s3_rgb;
    end

    a_skid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("output skid overfilled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && out_full) |=> (r_v3 && $stable(r_s3_rgb)))
        else $error("back stage 3 lost a word while stalled");

    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && out_full) |-> !o_q_pop)
        else $error("mid queue popped while back is stalled");

endmodule

>>> rtl/hsv_to_rgb_integer.sv
// HSV to RGB converter, integer datapath. Push an hsv word (hue reduced modulo
// 360, sat and val 0..255) while full is low; each word yields one rgb word,
// popped while empty is low. One word per clock is sustained while the reader
// keeps popping: a four-stage front (hue reduction, sector split, brightness
// terms) feeds a four-deep queue, and a three-stage back (ramps, channel
// routing, divide by 255*255/MAX_LEVEL) feeds a two-word output buffer. The
// front and back each stall only when the stage after them is full. Sums and
// differences wrap at 16 bits and each channel is truncated to 8 bits.
module hsv_to_rgb_integer import hsvc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_hsv_in  i_hsv,
    output logic     full,
    output logic     empty,
    input  logic     pop,
    output t_rgb_out o_rgb
);

    logic q_push, q_full, q_pop, q_empty;
    t_mid q_wdata, q_rdata;

    hsvc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_hsv    (i_hsv),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    hsvc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    hsvc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_rgb     (o_rgb)
    );

endmodule

>>> bench/tb_hsv_to_rgb_integer.sv
module tb_hsv_to_rgb_integer import hsvc_pkg::*;;

    localparam int unsigned DEG_CIRCLE  = 360;
    localparam int unsigned DEG_SECTOR  = 60;
    localparam int unsigned DEG_RAMP    = 120;
    localparam int unsigned LEVEL_FULL  = 255;
    localparam int unsigned N_PROBES    = 23;
    localparam int unsigned N_RANDOM    = 1330;
    localparam int unsigned IDLE_PCT    = 9;
    localparam int unsigned CALM_FIRST  = 600;
    localparam int unsigned CALM_LAST   = 900;
    localparam int unsigned DRAIN_CYC   = 16;
    localparam int unsigned PRINT_CAP   = 100;

    typedef struct {
        t_hsv_in  hsv;
        bit       typed;   // rgb below is known by hand
        t_rgb_out rgb;
    } t_probe;

    logic     i_clk;
    logic     i_rst_n;
    logic     push;
    t_hsv_in  i_hsv;
    logic     full;
    logic     empty;
    logic     pop;
    t_rgb_out o_rgb;

    t_rgb_out    rgb_due[$];
    int unsigned miss_count;
    int unsigned rgb_seen;
    bit          calm;

    // Directed words: black, white, primaries, hue wrap, sector edges
    t_probe probes [N_PROBES] = '{
        '{{16'd0,     8'd0,   8'd0  }, 1'b1, {8'd0,   8'd0,   8'd0  }},
        '{{16'd0,     8'd255, 8'd0  }, 1'b1, {8'd0,   8'd0,   8'd0  }},
        '{{16'd0,     8'd0,   8'd255}, 1'b1, {8'd255, 8'd255, 8'd255}},
        '{{16'd0,     8'd255, 8'd255}, 1'b1, {8'd255, 8'd0,   8'd0  }},
        '{{16'd120,   8'd255, 8'd255}, 1'b1, {8'd0,   8'd255, 8'd0  }},
        '{{16'd240,   8'd255, 8'd255}, 1'b1, {8'd0,   8'd0,   8'd255}},
        '{{16'd360,   8'd255, 8'd255}, 1'b1, {8'd255, 8'd0,   8'd0  }},
        '{{16'd65520, 8'd255, 8'd255}, 1'b1, {8'd255, 8'd0,   8'd0  }},
        '{{16'd200,   8'd0,   8'd128}, 1'b1, {8'd128, 8'd128, 8'd128}},
        '{{16'd65535, 8'd255, 8'd255}, 1'b0, '0},
        '{{16'd359,   8'd255, 8'd255}, 1'b0, '0},
        '{{16'd60,    8'd255, 8'd255}, 1'b0, '0},
        '{{16'd180,   8'd255, 8'd255}, 1'b0, '0},
        '{{16'd300,   8'd255, 8'd255}, 1'b0, '0},
        '{{16'd59,    8'd255, 8'd255}, 1'b0, '0},
        '{{16'd61,    8'd128, 8'd200}, 1'b0, '0},
        '{{16'd179,   8'd1,   8'd1  }, 1'b0, '0},
        '{{16'd239,   8'd254, 8'd254}, 1'b0, '0},
        '{{16'd299,   8'd255, 8'd128}, 1'b0, '0},
        '{{16'd32768, 8'd170, 8'd85 }, 1'b0, '0},
        '{{16'd719,   8'd255, 8'd255}, 1'b0, '0},
        '{{16'hAAAA,  8'h55,  8'hAA }, 1'b0, '0},
        '{{16'h5555,  8'hAA,  8'h55 }, 1'b0, '0}
    };

    hsv_to_rgb_integer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_hsv   (i_hsv),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_rgb   (o_rgb)
    );

    // Clock, period 8
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Expected color of one hsv word; sums and differences wrap at 16 bits
    function automatic t_rgb_out rgb_of(t_hsv_in w);
        int unsigned h, s, v, sect, offs, vs, div;
        logic [15:0] ceil_t, floor_t, incline, ramp, half;
        logic [15:0] ra, rb, rc, rd, r, g, b;
        t_rgb_out    o;
        h       = w.hue % DEG_CIRCLE;
        s       = w.sat;
        v       = w.val;
        sect    = h / DEG_SECTOR;
        offs    = h - sect * DEG_SECTOR;
        vs      = v * s;
        ceil_t  = 16'(v * LEVEL_FULL);
        floor_t = 16'(v * (LEVEL_FULL - s));
        incline = 16'(vs / DEG_RAMP);
        ramp    = 16'(incline * offs);
        half    = 16'(vs / 2);
        ra      = floor_t + ramp;
        rb      = floor_t + half + ramp;
        rc      = ceil_t - ramp;
        rd      = ceil_t - half - ramp;
        case (t_sector'(sect))
            SECT_0: begin r = rc;      g = ra;      b = floor_t; end
            SECT_1: begin r = rd;      g = rb;      b = floor_t; end
            SECT_2: begin r = floor_t; g = rc;      b = ra;      end
            SECT_3: begin r = floor_t; g = rd;      b = rb;      end
            SECT_4: begin r = ra;      g = floor_t; b = rc;      end
            default: begin r = rb;     g = floor_t; b = rd;      end
        endcase
        div = ((LEVEL_FULL * LEVEL_FULL) / MAX_LEVEL) % 65536;
        if (div == 0) begin
            div = 1;
        end
        o.red   = 8'(r / div);
        o.green = 8'(g / div);
        o.blue  = 8'(b / div);
        return o;
    endfunction

    // Byte biased toward its extremes now and then
    function automatic logic [7:0] rim_byte();
        logic [7:0] pick [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
        if ($urandom_range(0, 4) == 0) begin
            return pick[$urandom_range(0, 3)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Random hsv word: raw 16-bit hue, in-circle hue, or a sector boundary
    function automatic t_hsv_in random_hsv();
        t_hsv_in     w;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            w.hue = 16'($urandom_range(0, 65535));
        end else if (kind < 8) begin
            w.hue = 16'($urandom_range(0, DEG_CIRCLE - 1));
        end else begin
            w.hue = 16'(($urandom_range(0, 5) * DEG_SECTOR + DEG_SECTOR - 1
                         + $urandom_range(0, 2)) % DEG_CIRCLE);
        end
        w.sat = rim_byte();
        w.val = rim_byte();
        return w;
    endfunction

    task automatic report_miss(string what, logic [23:0] got, logic [23:0] want);
        if (miss_count < PRINT_CAP) begin
            $display("%0t: %s mismatch on rgb word %0d: got %0h, want %0h",
                     $realtime, what, rgb_seen, got, want);
        end
        miss_count++;
    endtask

    // Sender side: push words, record the expected color once accepted
    initial begin
        t_hsv_in  word;
        t_rgb_out want;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_hsv      = '0;
        calm       = 1'b0;
        miss_count = 0;
        rgb_seen   = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_PROBES + N_RANDOM; i++) begin
            if (i < N_PROBES) begin
                word = probes[i].hsv;
                want = probes[i].typed ? probes[i].rgb : rgb_of(word);
            end else begin
                word = random_hsv();
                want = rgb_of(word);
            end
            calm = (i >= CALM_FIRST) && (i < CALM_LAST);
            @(negedge i_clk);
            while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                push <= 1'b0;
                @(negedge i_clk);
            end
            push  <= 1'b1;
            i_hsv <= word;
            @(posedge i_clk);
            while (full) @(posedge i_clk);
            rgb_due.push_back(want);
        end
        @(negedge i_clk);
        push <= 1'b0;
        while (rgb_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (miss_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver side: pop with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check each popped word against the oldest expected color
    always @(posedge i_clk) begin
        t_rgb_out want;
        if (i_rst_n && pop && !empty) begin
            if (rgb_due.size() == 0) begin
                report_miss("unexpected word", o_rgb, '0);
            end else begin
                want = rgb_due.pop_front();
                if (o_rgb.red !== want.red) begin
                    report_miss("red", 24'(o_rgb.red), 24'(want.red));
                end
                if (o_rgb.green !== want.green) begin
                    report_miss("green", 24'(o_rgb.green), 24'(want.green));
                end
                if (o_rgb.blue !== want.blue) begin
                    report_miss("blue", 24'(o_rgb.blue), 24'(want.blue));
                end
            end
            rgb_seen++;
        end
    end

    // Hang guard
    initial begin
        #(8 * 200000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
